// ----- rtl/kvt_pkg.sv -----
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and codes for the key/value table: operation and status
// codes, controller states and default sizes.
// ----------------------------------------------------------------------------
package kvt_pkg;

  // default sizes
  localparam int ENTRIES_DEFAULT    = 16;
  localparam int KEY_BITS_DEFAULT   = 32;
  localparam int VALUE_BITS_DEFAULT = 32;

  // field widths on the ports
  localparam int OP_W     = 3;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_GET    = 3'd0;
  localparam logic [OP_W-1:0] OP_SET    = 3'd1;
  localparam logic [OP_W-1:0] OP_GETINS = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL    = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_VREAD,
    ST_DONE
  } kvt_state_t;

endpackage

// ----- rtl/kvt_ram.sv -----
// ----------------------------------------------------------------------------
// kvt_ram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module kvt_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic [AW-1:0]    addr,
  input  logic             we,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- rtl/key_value_table_core.sv -----
// ----------------------------------------------------------------------------
// key_value_table_core
// Bounded key to value table with get, set, get-or-insert, delete and clear.
// ----------------------------------------------------------------------------
// Keys and values sit in two single-port RAMs; slot valid bits and the entry
// count are flops. Each request walks the key RAM one slot per cycle from
// slot 0 until a valid slot holds the key or the last slot is compared; a
// hit then also reads the value RAM. Clear and unknown operation codes skip
// the walk and go straight to the finish state. The finish state
// also waits while the previous result word is still held in the output
// register. The walk also notes the lowest free slot, which an insert uses.
// Every request gives one result word; a new request is taken while the
// previous result still waits on the output register. After reset the table
// is empty at once: no clearing pass.
// ----------------------------------------------------------------------------
module key_value_table_core #(
  parameter int ENTRIES    = kvt_pkg::ENTRIES_DEFAULT,
  parameter int KEY_BITS   = kvt_pkg::KEY_BITS_DEFAULT,
  parameter int VALUE_BITS = kvt_pkg::VALUE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] key, [63:32] write_value
  input  logic [2:0]  s_tuser,   // [2:0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] read_value, [36:32] entry_count, rest zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  import kvt_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int VW = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam logic [IW-1:0] LAST_SLOT = IW'(ENTRIES - 1);

  kvt_state_t state, state_next;

  // request registers
  logic [OP_W-1:0] op_q;
  logic [KW-1:0]   key_q;
  logic [VW-1:0]   val_q;

  // walk registers
  logic [IW-1:0] cmp_idx;
  logic [IW-1:0] slot;
  logic          hit;
  logic          free_ok;

  // table state
  logic [ENTRIES-1:0] valid;
  logic [CW-1:0]      count;

  // RAM ports
  logic [IW-1:0] key_addr, val_addr;
  logic          key_we, key_re, val_we, val_re;
  logic [KW-1:0] key_rd;
  logic [VW-1:0] val_rd, val_wd;

  // control
  logic in_fire, done_fire, out_free, hit_now, free_now;

  // result decode
  logic [STATUS_W-1:0] res_status;
  logic [VW-1:0]       res_value;
  logic                do_insert, do_update, do_delete, do_clear;

  logic [CW+COUNT_W-1:0] count_ext;
  logic [VW+VALUE_W-1:0] value_ext;

  kvt_ram #(.DEPTH(ENTRIES), .WIDTH(KW)) u_key_ram (
    .clk   (clk),
    .addr  (key_addr),
    .we    (key_we),
    .wdata (key_q),
    .re    (key_re),
    .rdata (key_rd)
  );

  kvt_ram #(.DEPTH(ENTRIES), .WIDTH(VW)) u_val_ram (
    .clk   (clk),
    .addr  (val_addr),
    .we    (val_we),
    .wdata (val_wd),
    .re    (val_re),
    .rdata (val_rd)
  );

  // compare of the slot whose key has just come out of the RAM
  assign hit_now  = valid[cmp_idx] && (key_rd == key_q);
  assign free_now = !valid[cmp_idx] && !free_ok;
  assign out_free = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == OP_GET || s_tuser == OP_SET || s_tuser == OP_GETINS ||
              s_tuser == OP_DEL) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (hit_now) begin
          state_next = ST_VREAD;
        end else if (cmp_idx == LAST_SLOT) begin
          state_next = ST_DONE;
        end
      end
      ST_VREAD: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs: handshake and RAM control
  always_comb begin
    s_tready  = 1'b0;
    done_fire = 1'b0;
    key_re    = 1'b0;
    val_re    = 1'b0;
    key_addr  = slot;
    val_addr  = slot;
    case (state)
      ST_IDLE: begin
        s_tready = !rst;
        key_re   = s_tvalid;
        key_addr = '0;
      end
      ST_SCAN: begin
        key_re   = 1'b1;
        key_addr = cmp_idx + 1'b1;
        val_re   = hit_now;
        val_addr = cmp_idx;
      end
      ST_DONE: done_fire = out_free;
      default: ;
    endcase
  end

  assign in_fire = s_tvalid && s_tready;

  // result and write decode for the finished walk
  always_comb begin
    res_status = STAT_OK;
    res_value  = '0;
    do_insert  = 1'b0;
    do_update  = 1'b0;
    do_delete  = 1'b0;
    do_clear   = 1'b0;
    case (op_q)
      OP_GET: begin
        if (hit) res_value = val_rd;
        else     res_status = STAT_NOTFOUND;
      end
      OP_SET: begin
        if (hit)          do_update = 1'b1;
        else if (free_ok) do_insert = 1'b1;
        else              res_status = STAT_FULL;
      end
      OP_GETINS: begin
        if (hit)          res_value = val_rd;
        else if (free_ok) do_insert = 1'b1;
        else              res_status = STAT_FULL;
      end
      OP_DEL: begin
        if (hit) do_delete = 1'b1;
        else     res_status = STAT_NOTFOUND;
      end
      OP_CLEAR: do_clear = 1'b1;
      default: ;
    endcase
  end

  assign key_we = done_fire && do_insert;
  assign val_we = done_fire && (do_insert || do_update);
  assign val_wd = (op_q == OP_SET) ? val_q : '0;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q  <= s_tuser;
      key_q <= s_tdata[KW-1:0];
      val_q <= s_tdata[KEY_W +: VW];
    end
  end

  // slot walk
  always_ff @(posedge clk) begin
    if (rst) begin
      hit     <= 1'b0;
      free_ok <= 1'b0;
      cmp_idx <= '0;
    end else if (in_fire) begin
      hit     <= 1'b0;
      free_ok <= 1'b0;
      cmp_idx <= '0;
    end else if (state == ST_SCAN) begin
      cmp_idx <= cmp_idx + 1'b1;
      if (hit_now) begin
        hit <= 1'b1;
      end else if (free_now) begin
        free_ok <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN && (hit_now || free_now)) begin
      slot <= cmp_idx;
    end
  end

  // valid bits and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else if (done_fire) begin
      if (do_clear) begin
        valid <= '0;
        count <= '0;
      end else if (do_insert) begin
        valid[slot] <= 1'b1;
        count       <= count + 1'b1;
      end else if (do_delete) begin
        valid[slot] <= 1'b0;
        if (count != '0) count <= count - 1'b1;
      end
    end
  end

  // output register
  always_comb begin
    count_ext = '0;
    value_ext = '0;
    if (do_clear) begin
      count_ext = '0;
    end else if (do_insert) begin
      count_ext = {{COUNT_W{1'b0}}, count + 1'b1};
    end else if (do_delete && count != '0) begin
      count_ext = {{COUNT_W{1'b0}}, count - 1'b1};
    end else begin
      count_ext = {{COUNT_W{1'b0}}, count};
    end
    value_ext = {{VALUE_W{1'b0}}, res_value};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      m_tuser <= res_status;
      m_tdata <= {3'b000, count_ext[COUNT_W-1:0], value_ext[VALUE_W-1:0]};
    end
  end

  // checks
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    count == CW'($countones(valid)))
    else $error("entry count disagrees with valid bits");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ENTRIES))
    else $error("entry count above table size");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_DONE))
    else $error("result word raised outside the finish state");

  a_vread_has_hit: assert property (@(posedge clk) disable iff (rst)
    state == ST_VREAD |-> hit)
    else $error("value read without a key hit");

endmodule
